// File: src/all_pairs_shortest_paths_defines.svh
// Assertion macros for the all-pairs shortest paths block.
// Used by the port checker; no other dependencies.
`ifndef ALL_PAIRS_SHORTEST_PATHS_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATHS_DEFINES_SVH

// Clocked property, disabled while reset is high.
`define APSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds through reset.
`define APSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/apsp_pkg.sv
// Shared types, constants and helper functions for the shortest paths block.
// No dependencies; every other file but the defines header refers to this package by scoped names.
package apsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES    = 64;
  localparam int WEIGHT_BITS  = 12;

  localparam int VERT_BITS = $clog2(MAX_VERTICES);
  localparam int VCNT_BITS = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_BITS = $clog2(MAX_EDGES);
  localparam int ECNT_BITS = $clog2(MAX_EDGES + 1);
  localparam int MAT_BITS  = 2 * VERT_BITS;
  localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int DIST_BITS = 16;
  // Bellman-Ford can chain every edge in each round: 64 * 15 * 2048 < 2^23
  localparam int DATA_BITS = 24;

  typedef logic [VERT_BITS-1:0]        vert_t;
  typedef logic [VCNT_BITS-1:0]        vcnt_t;
  typedef logic [EIDX_BITS-1:0]        eidx_t;
  typedef logic [ECNT_BITS-1:0]        ecnt_t;
  typedef logic [MAT_BITS-1:0]         maddr_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic signed [DIST_BITS-1:0] dist_t;

  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_ADD     = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NO_RESULT = 2'd3;

  localparam data_t SAT_HI = data_t'((2 ** (DIST_BITS - 1)) - 1);
  localparam data_t SAT_LO = data_t'(-(2 ** (DIST_BITS - 1)));

  typedef struct packed {
    vert_t   src;
    vert_t   dst;
    weight_t w;
  } edge_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_COMPUTE,
    OP_QUERY
  } eng_op_t;

  typedef struct packed {
    logic    start;
    eng_op_t op;
    vert_t   s;
    vert_t   d;
    weight_t w;
    vcnt_t   n;
    ecnt_t   count;
  } eng_cmd_t;

  typedef struct packed {
    logic  done;
    logic  cycle;
    logic  reach;
    dist_t path_dist;
  } eng_rsp_t;

  function automatic vcnt_t active_count(vcnt_t vc);
    if (vc == '0) return VCNT_BITS'(1);
    if (vc > VCNT_BITS'(MAX_VERTICES)) return VCNT_BITS'(MAX_VERTICES);
    return vc;
  endfunction

  function automatic data_t widen(weight_t w);
    return data_t'(w);
  endfunction

  function automatic dist_t sat_dist(data_t x);
    if (x > SAT_HI) return dist_t'(SAT_HI);
    if (x < SAT_LO) return dist_t'(SAT_LO);
    return dist_t'(x);
  endfunction

  function automatic logic edge_live(edge_t e, vcnt_t n);
    return (VCNT_BITS'(e.src) < n) && (VCNT_BITS'(e.dst) < n);
  endfunction

endpackage

// File: src/apsp_if.sv
// Handshake channels of the shortest paths block: request, result, configuration.
// Depends on apsp_pkg for field types.
interface apsp_req_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  apsp_pkg::vert_t        src_vertex;
  apsp_pkg::vert_t        dst_vertex;
  apsp_pkg::weight_t      edge_weight;
  modport source (output valid, req_type, src_vertex, dst_vertex, edge_weight, input ready);
  modport sink   (input valid, req_type, src_vertex, dst_vertex, edge_weight, output ready);
endinterface

interface apsp_res_if;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  apsp_pkg::dist_t distance;
  logic            reachable;
  logic            negative_cycle;
  modport source (output valid, status, distance, reachable, negative_cycle, input ready);
  modport sink   (input valid, status, distance, reachable, negative_cycle, output ready);
endinterface

interface apsp_cfg_if;
  logic            valid;
  logic            ready;
  apsp_pkg::vcnt_t vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// File: src/apsp_alu.sv
// Shared add/subtract and signed compare unit of the path engine.
// Depends on apsp_pkg.
module apsp_alu (
  input  apsp_pkg::data_t a,
  input  apsp_pkg::data_t b,
  input  logic            sub,
  output apsp_pkg::data_t sum,
  output logic            lt
);

  assign sum = sub ? (a - b) : (a + b);
  assign lt  = (a < b);

endmodule

// File: src/apsp_engine.sv
// Sequencer, edge store, potential, distance and result memories.
// Runs Bellman-Ford, per-source Dijkstra and queries on apsp_alu; depends on apsp_pkg.
module apsp_engine (
  input  logic                clk,
  input  logic                rst,
  input  apsp_pkg::eng_cmd_t  cmd,
  output apsp_pkg::eng_rsp_t  rsp
);

  localparam int VB = apsp_pkg::VERT_BITS;

  typedef enum logic [4:0] {
    E_IDLE, E_PINIT, E_EDGE_START, E_BF_RD, E_BF_SRC, E_BF_DST, E_BF_UPD, E_ROUND_END,
    E_DJ_INIT, E_DJ_HS, E_SC_RD, E_SC_CMP, E_SC_END, E_RX_RD, E_RX_CHK, E_RX_PA,
    E_RX_PB, E_RX_ADD, E_RX_CMP, E_K_END, E_WB_RD, E_WB_A, E_WB_B, E_WB_WR,
    E_Q_WAIT, E_DONE
  } state_t;

  state_t state;
  apsp_pkg::vcnt_t n, v, k, sv, rnd;
  apsp_pkg::ecnt_t count, e;
  apsp_pkg::vert_t qs, qd, best;
  logic            best_valid, chk, cycle;
  apsp_pkg::data_t bestd, hs, acc;
  logic [apsp_pkg::MAX_VERTICES-1:0] seen, done_v;

  apsp_pkg::edge_t edge_mem [apsp_pkg::MAX_EDGES];
  apsp_pkg::edge_t edge_q;
  apsp_pkg::data_t pot_mem [apsp_pkg::MAX_VERTICES];
  apsp_pkg::data_t pot_q;
  apsp_pkg::data_t d_mem [apsp_pkg::MAX_VERTICES];
  apsp_pkg::data_t d_q;
  logic [apsp_pkg::DIST_BITS:0] mat_mem [apsp_pkg::MAT_DEPTH];
  logic [apsp_pkg::DIST_BITS:0] mat_q;

  apsp_pkg::data_t alu_a, alu_b, alu_sum;
  logic            alu_sub, alu_lt;
  apsp_pkg::vert_t pot_ra, pot_wa, d_ra, d_wa;
  logic            pot_we, d_we, mat_we;
  apsp_pkg::data_t pot_wd, d_wd;
  logic [apsp_pkg::DIST_BITS:0] mat_wd;
  apsp_pkg::maddr_t mat_wa;
  logic            e_last, v_last;

  apsp_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  assign e_last = ((e + apsp_pkg::ECNT_BITS'(1)) == count);
  assign v_last = ((v + apsp_pkg::VCNT_BITS'(1)) == n);
  assign mat_wa = {sv[VB-1:0], v[VB-1:0]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    pot_ra  = '0;
    d_ra    = '0;
    pot_we  = 1'b0;
    pot_wa  = '0;
    pot_wd  = '0;
    d_we    = 1'b0;
    d_wa    = '0;
    d_wd    = '0;
    mat_we  = 1'b0;
    mat_wd  = '0;
    case (state)
      E_PINIT: begin
        pot_we = 1'b1;
        pot_wa = v[VB-1:0];
      end
      E_BF_SRC: pot_ra = edge_q.src;
      E_BF_DST: begin
        alu_a  = pot_q;
        alu_b  = apsp_pkg::widen(edge_q.w);
        pot_ra = edge_q.dst;
      end
      E_BF_UPD: begin
        alu_a  = acc;
        alu_b  = pot_q;
        pot_we = alu_lt && !chk;
        pot_wa = edge_q.dst;
        pot_wd = acc;
      end
      E_DJ_INIT: begin
        pot_ra = sv[VB-1:0];
        d_we   = 1'b1;
        d_wa   = sv[VB-1:0];
      end
      E_SC_RD: d_ra = v[VB-1:0];
      E_SC_CMP: begin
        alu_a = d_q;
        alu_b = bestd;
      end
      E_RX_CHK: pot_ra = edge_q.src;
      E_RX_PA: begin
        alu_a  = pot_q;
        alu_b  = apsp_pkg::widen(edge_q.w);
        pot_ra = edge_q.dst;
      end
      E_RX_PB: begin
        alu_a   = acc;
        alu_b   = pot_q;
        alu_sub = 1'b1;
      end
      E_RX_ADD: begin
        alu_a = acc;
        alu_b = bestd;
        d_ra  = edge_q.dst;
      end
      E_RX_CMP: begin
        alu_a = acc;
        alu_b = d_q;
        d_we  = !seen[edge_q.dst] || alu_lt;
        d_wa  = edge_q.dst;
        d_wd  = acc;
      end
      E_WB_RD: begin
        pot_ra = v[VB-1:0];
        d_ra   = v[VB-1:0];
      end
      E_WB_A: begin
        alu_a = d_q;
        alu_b = pot_q;
      end
      E_WB_B: begin
        alu_a   = acc;
        alu_b   = hs;
        alu_sub = 1'b1;
      end
      E_WB_WR: begin
        mat_we = 1'b1;
        mat_wd = seen[v[VB-1:0]] ? {1'b1, apsp_pkg::sat_dist(acc)} : '0;
      end
      default: ;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.start && cmd.op == apsp_pkg::OP_ADD) begin
      edge_mem[cmd.count[apsp_pkg::EIDX_BITS-1:0]] <= '{src: cmd.s, dst: cmd.d, w: cmd.w};
    end
    edge_q <= edge_mem[e[apsp_pkg::EIDX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pot_we) begin
      pot_mem[pot_wa] <= pot_wd;
    end
    pot_q <= pot_mem[pot_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      d_mem[d_wa] <= d_wd;
    end
    d_q <= d_mem[d_ra];
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    mat_q <= mat_mem[{qs, qd}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      cycle <= 1'b0;
    end else begin
      case (state)
        E_IDLE: begin
          if (cmd.start) begin
            n     <= cmd.n;
            count <= cmd.count;
            qs    <= cmd.s;
            qd    <= cmd.d;
            cycle <= 1'b0;
            v     <= '0;
            case (cmd.op)
              apsp_pkg::OP_COMPUTE: state <= E_PINIT;
              apsp_pkg::OP_QUERY:   state <= E_Q_WAIT;
              default:              state <= E_IDLE;
            endcase
          end
        end
        E_PINIT: begin
          v <= v + apsp_pkg::VCNT_BITS'(1);
          if (v_last) begin
            rnd   <= '0;
            chk   <= (n == apsp_pkg::VCNT_BITS'(1));
            state <= E_EDGE_START;
          end
        end
        E_EDGE_START: begin
          e     <= '0;
          state <= (count == '0) ? E_ROUND_END : E_BF_RD;
        end
        E_BF_RD: state <= E_BF_SRC;
        E_BF_SRC: begin
          if (apsp_pkg::edge_live(edge_q, n)) begin
            state <= E_BF_DST;
          end else if (e_last) begin
            state <= E_ROUND_END;
          end else begin
            e     <= e + apsp_pkg::ECNT_BITS'(1);
            state <= E_BF_RD;
          end
        end
        E_BF_DST: begin
          acc   <= alu_sum;
          state <= E_BF_UPD;
        end
        E_BF_UPD: begin
          if (alu_lt && chk) begin
            cycle <= 1'b1;
            state <= E_DONE;
          end else if (e_last) begin
            state <= E_ROUND_END;
          end else begin
            e     <= e + apsp_pkg::ECNT_BITS'(1);
            state <= E_BF_RD;
          end
        end
        E_ROUND_END: begin
          if (chk) begin
            sv    <= '0;
            state <= E_DJ_INIT;
          end else begin
            chk   <= ((rnd + apsp_pkg::VCNT_BITS'(2)) == n);
            rnd   <= rnd + apsp_pkg::VCNT_BITS'(1);
            state <= E_EDGE_START;
          end
        end
        E_DJ_INIT: begin
          // only the source starts out seen
          seen   <= apsp_pkg::MAX_VERTICES'(1) << sv[VB-1:0];
          done_v <= '0;
          k      <= '0;
          state  <= E_DJ_HS;
        end
        E_DJ_HS: begin
          hs         <= pot_q;
          v          <= '0;
          best_valid <= 1'b0;
          state      <= E_SC_RD;
        end
        E_SC_RD: state <= E_SC_CMP;
        E_SC_CMP: begin
          if (seen[v[VB-1:0]] && !done_v[v[VB-1:0]] && (!best_valid || alu_lt)) begin
            best       <= v[VB-1:0];
            bestd      <= d_q;
            best_valid <= 1'b1;
          end
          if (v_last) begin
            state <= E_SC_END;
          end else begin
            v     <= v + apsp_pkg::VCNT_BITS'(1);
            state <= E_SC_RD;
          end
        end
        E_SC_END: begin
          if (!best_valid) begin
            v     <= '0;
            state <= E_WB_RD;
          end else begin
            done_v[best] <= 1'b1;
            e            <= '0;
            state        <= (count == '0) ? E_K_END : E_RX_RD;
          end
        end
        E_RX_RD: state <= E_RX_CHK;
        E_RX_CHK: begin
          if (apsp_pkg::edge_live(edge_q, n) && edge_q.src == best) begin
            state <= E_RX_PA;
          end else if (e_last) begin
            state <= E_K_END;
          end else begin
            e     <= e + apsp_pkg::ECNT_BITS'(1);
            state <= E_RX_RD;
          end
        end
        E_RX_PA: begin
          acc   <= alu_sum;
          state <= E_RX_PB;
        end
        E_RX_PB: begin
          acc   <= alu_sum;
          state <= E_RX_ADD;
        end
        E_RX_ADD: begin
          acc   <= alu_sum;
          state <= E_RX_CMP;
        end
        E_RX_CMP: begin
          if (d_we) begin
            seen[edge_q.dst] <= 1'b1;
          end
          if (e_last) begin
            state <= E_K_END;
          end else begin
            e     <= e + apsp_pkg::ECNT_BITS'(1);
            state <= E_RX_RD;
          end
        end
        E_K_END: begin
          v <= '0;
          if ((k + apsp_pkg::VCNT_BITS'(1)) == n) begin
            state <= E_WB_RD;
          end else begin
            k          <= k + apsp_pkg::VCNT_BITS'(1);
            best_valid <= 1'b0;
            state      <= E_SC_RD;
          end
        end
        E_WB_RD: state <= E_WB_A;
        E_WB_A: begin
          acc   <= alu_sum;
          state <= E_WB_B;
        end
        E_WB_B: begin
          acc   <= alu_sum;
          state <= E_WB_WR;
        end
        E_WB_WR: begin
          if (!v_last) begin
            v     <= v + apsp_pkg::VCNT_BITS'(1);
            state <= E_WB_RD;
          end else if ((sv + apsp_pkg::VCNT_BITS'(1)) == n) begin
            state <= E_DONE;
          end else begin
            sv    <= sv + apsp_pkg::VCNT_BITS'(1);
            state <= E_DJ_INIT;
          end
        end
        E_Q_WAIT: state <= E_DONE;
        E_DONE:   state <= E_IDLE;
        default:  state <= E_IDLE;
      endcase
    end
  end

  assign rsp.done      = (state == E_DONE);
  assign rsp.cycle     = cycle;
  assign rsp.reach     = mat_q[apsp_pkg::DIST_BITS];
  assign rsp.path_dist = apsp_pkg::dist_t'(mat_q[apsp_pkg::DIST_BITS-1:0]);

endmodule

// File: src/all_pairs_shortest_paths.sv
// All-pairs shortest paths (Johnson): clear, add edge, compute, query per item.
// Compute runs on the single shared add/compare unit with one read port per memory.
// One item at a time; a finished result waits in the output register.
// Reset (synchronous): no edges, no valid results, no cycle flag, vertex count 16.
module all_pairs_shortest_paths (
  input  logic        clk,
  input  logic        rst,
  apsp_cfg_if.sink    cfg,
  apsp_req_if.sink    req,
  apsp_res_if.source  res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SEND
  } state_t;

  state_t              state;
  apsp_pkg::vcnt_t     vertex_count;
  apsp_pkg::ecnt_t     edge_count;
  logic                results_valid;
  logic                cycle_found;
  apsp_pkg::eng_cmd_t  cmd;
  apsp_pkg::eng_rsp_t  rsp;
  logic [1:0]          pend_status;
  apsp_pkg::dist_t     pend_dist;
  logic                pend_reach;
  logic                out_valid;
  logic [1:0]          out_status;
  apsp_pkg::dist_t     out_dist;
  logic                out_reach;
  logic                out_neg;
  apsp_pkg::vcnt_t     n;
  logic                bad_vertex;

  logic                cfg_fire;
  logic                req_fire;
  logic                send_fire;
  logic                eng_start;
  apsp_pkg::eng_op_t   op_next;
  state_t              state_next;
  apsp_pkg::ecnt_t     edge_count_next;
  logic                results_valid_next;
  logic                cycle_found_next;
  logic [1:0]          status_next;
  logic                out_valid_next;

  assign n          = apsp_pkg::active_count(vertex_count);
  assign bad_vertex = (apsp_pkg::VCNT_BITS'(req.src_vertex) >= n)
                   || (apsp_pkg::VCNT_BITS'(req.dst_vertex) >= n);

  apsp_engine u_engine (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // a register write wins over a request in the same cycle
  assign cfg.ready = !rst && (state == S_IDLE);
  assign req.ready = !rst && (state == S_IDLE) && !cfg.valid;

  assign cfg_fire = cfg.valid && cfg.ready;
  assign req_fire = req.valid && req.ready;

  always_comb begin
    state_next         = state;
    edge_count_next    = edge_count;
    results_valid_next = results_valid;
    cycle_found_next   = cycle_found;
    status_next        = apsp_pkg::ST_OK;
    eng_start          = 1'b0;
    op_next            = apsp_pkg::OP_ADD;
    if (cfg_fire) begin
      results_valid_next = 1'b0;
    end
    if (req_fire) begin
      state_next = S_SEND;
      case (req.req_type)
        apsp_pkg::REQ_CLEAR: begin
          edge_count_next    = '0;
          results_valid_next = 1'b0;
          cycle_found_next   = 1'b0;
        end
        apsp_pkg::REQ_ADD: begin
          if (bad_vertex) begin
            status_next = apsp_pkg::ST_RANGE;
          end else if (edge_count >= apsp_pkg::ECNT_BITS'(apsp_pkg::MAX_EDGES)) begin
            status_next = apsp_pkg::ST_FULL;
          end else begin
            // store write goes through the command register; nothing else to wait for
            eng_start          = 1'b1;
            op_next            = apsp_pkg::OP_ADD;
            edge_count_next    = edge_count + apsp_pkg::ECNT_BITS'(1);
            results_valid_next = 1'b0;
          end
        end
        apsp_pkg::REQ_COMPUTE: begin
          eng_start  = 1'b1;
          op_next    = apsp_pkg::OP_COMPUTE;
          state_next = S_RUN;
        end
        default: begin
          if (bad_vertex) begin
            status_next = apsp_pkg::ST_RANGE;
          end else if (!results_valid) begin
            status_next = apsp_pkg::ST_NO_RESULT;
          end else begin
            eng_start  = 1'b1;
            op_next    = apsp_pkg::OP_QUERY;
            state_next = S_RUN;
          end
        end
      endcase
    end
    if (state == S_RUN && rsp.done) begin
      state_next = S_SEND;
      if (cmd.op == apsp_pkg::OP_COMPUTE) begin
        cycle_found_next   = rsp.cycle;
        results_valid_next = !rsp.cycle;
      end
    end
    // hold until the output register is free
    send_fire = (state == S_SEND) && (!out_valid || res.ready);
    if (send_fire) begin
      state_next = S_IDLE;
    end
    out_valid_next = send_fire || (out_valid && !res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= apsp_pkg::VCNT_BITS'(apsp_pkg::MAX_VERTICES);
      edge_count    <= '0;
      results_valid <= 1'b0;
      cycle_found   <= 1'b0;
      cmd.start     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      edge_count    <= edge_count_next;
      results_valid <= results_valid_next;
      cycle_found   <= cycle_found_next;
      cmd.start     <= eng_start;
      out_valid     <= out_valid_next;
      if (cfg_fire) begin
        vertex_count <= cfg.vertex_count;
      end
      if (req_fire) begin
        cmd.s       <= req.src_vertex;
        cmd.d       <= req.dst_vertex;
        cmd.w       <= req.edge_weight;
        cmd.n       <= n;
        cmd.count   <= edge_count;
        pend_status <= status_next;
        pend_dist   <= '0;
        pend_reach  <= 1'b0;
        if (eng_start) begin
          cmd.op <= op_next;
        end
      end else if (state == S_RUN && rsp.done && cmd.op != apsp_pkg::OP_COMPUTE
                   && rsp.reach) begin
        pend_dist  <= rsp.path_dist;
        pend_reach <= 1'b1;
      end
      if (send_fire) begin
        out_status <= pend_status;
        out_dist   <= pend_dist;
        out_reach  <= pend_reach;
        out_neg    <= cycle_found;
      end
    end
  end

  assign res.valid          = out_valid;
  assign res.status         = out_status;
  assign res.distance       = out_dist;
  assign res.reachable      = out_reach;
  assign res.negative_cycle = out_neg;

endmodule

// File: src/apsp_checker.sv
// Port-level checks on the result channel of the shortest paths block.
// Uses the assertion macros header and apsp_pkg; bound to the top level below.
`include "all_pairs_shortest_paths_defines.svh"

module apsp_checker (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_ready,
  input logic [1:0]      res_status,
  input apsp_pkg::dist_t res_distance,
  input logic            res_reachable,
  input logic            res_negative_cycle
);

  `APSP_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_distance) && $stable(res_status), "result changed while stalled")
  `APSP_ASSERT(a_fail_empty, clk, rst, res_valid && (res_status != apsp_pkg::ST_OK) |-> !res_reachable && (res_distance == '0), "failed item carries a distance")
  `APSP_ASSERT(a_cycle_no_reach, clk, rst, res_valid && res_negative_cycle |-> !res_reachable, "reachable reported with negative cycle")
  `APSP_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !res_valid, "result valid right after reset")

endmodule

bind all_pairs_shortest_paths apsp_checker u_apsp_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_status         (res.status),
  .res_distance       (res.distance),
  .res_reachable      (res.reachable),
  .res_negative_cycle (res.negative_cycle)
);

// File: test/tb_top.sv
// Self-checking testbench for all_pairs_shortest_paths: directed and random items,
// with an own Johnson predictor, random idling on both channels and several vertex counts.
// Depends on apsp_pkg and the handshake interfaces in apsp_if.sv.
module tb_top;

  typedef struct {
    logic [1:0]      status;
    apsp_pkg::dist_t distance;
    logic            reach;
    logic            neg_cycle;
  } path_answer_t;

  logic clk = 1'b0;
  logic rst;

  apsp_cfg_if cfg_ch();
  apsp_req_if req_ch();
  apsp_res_if res_ch();

  all_pairs_shortest_paths i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  always #1 clk = ~clk;

  // Predictor state
  int              graph_src [apsp_pkg::MAX_EDGES];
  int              graph_dst [apsp_pkg::MAX_EDGES];
  longint          graph_w [apsp_pkg::MAX_EDGES];
  int              graph_edges;
  longint          vert_pot [apsp_pkg::MAX_VERTICES];
  apsp_pkg::dist_t dist_tab [apsp_pkg::MAX_VERTICES * apsp_pkg::MAX_VERTICES];
  bit              reach_tab [apsp_pkg::MAX_VERTICES * apsp_pkg::MAX_VERTICES];
  bit              tables_ok;
  bit              cycle_seen;
  logic [4:0]      vert_cfg;

  path_answer_t pending_answers[$];
  int errors = 0;
  int items_sent = 0;
  int answers_seen = 0;
  int solves = 0;
  int cycles_hit = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic int live_vertices();
    if (vert_cfg == 0) return 1;
    if (vert_cfg > apsp_pkg::MAX_VERTICES) return apsp_pkg::MAX_VERTICES;
    return int'(vert_cfg);
  endfunction

  function automatic apsp_pkg::dist_t clamp16(longint v);
    if (v > 32767) return apsp_pkg::dist_t'(32767);
    if (v < -32768) return apsp_pkg::dist_t'(-32768);
    return apsp_pkg::dist_t'(v);
  endfunction

  function automatic bit is_live(int e, int n);
    return graph_src[e] < n && graph_dst[e] < n;
  endfunction

  function automatic void dijkstra_from(int s, int n);
    longint d [apsp_pkg::MAX_VERTICES];
    bit seen [apsp_pkg::MAX_VERTICES];
    bit done [apsp_pkg::MAX_VERTICES];
    int best;
    int a;
    int b;
    longint nd;
    for (int v = 0; v < n; v++) begin
      d[v] = 0; seen[v] = 0; done[v] = 0;
    end
    seen[s] = 1;
    for (int k = 0; k < n; k++) begin
      best = n;
      for (int v = 0; v < n; v++)
        if (seen[v] && !done[v] && (best == n || d[v] < d[best])) best = v;
      if (best == n) break;
      done[best] = 1;
      for (int e = 0; e < graph_edges; e++) begin
        a = graph_src[e];
        b = graph_dst[e];
        if (!is_live(e, n) || a != best) continue;
        nd = d[a] + graph_w[e] + vert_pot[a] - vert_pot[b];
        if (!seen[b] || nd < d[b]) begin
          d[b] = nd; seen[b] = 1;
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      reach_tab[s * apsp_pkg::MAX_VERTICES + v] = seen[v];
      dist_tab[s * apsp_pkg::MAX_VERTICES + v] =
        seen[v] ? clamp16(d[v] - vert_pot[s] + vert_pot[v]) : '0;
    end
  endfunction

  function automatic void solve_graph();
    int n;
    longint c;
    n = live_vertices();
    for (int v = 0; v < n; v++) vert_pot[v] = 0;
    for (int r = 0; r + 1 < n; r++)
      for (int e = 0; e < graph_edges; e++) begin
        if (!is_live(e, n)) continue;
        c = vert_pot[graph_src[e]] + graph_w[e];
        if (c < vert_pot[graph_dst[e]]) vert_pot[graph_dst[e]] = c;
      end
    for (int e = 0; e < graph_edges; e++) begin
      if (!is_live(e, n)) continue;
      if (vert_pot[graph_src[e]] + graph_w[e] < vert_pot[graph_dst[e]]) begin
        cycle_seen = 1;
        tables_ok = 0;
        cycles_hit++;
        return;
      end
    end
    cycle_seen = 0;
    for (int v = 0; v < n; v++) dijkstra_from(v, n);
    tables_ok = 1;
  endfunction

  function automatic path_answer_t predict_answer(logic [1:0] kind, apsp_pkg::vert_t s,
                                                  apsp_pkg::vert_t d, apsp_pkg::weight_t w);
    path_answer_t ans;
    int n;
    n = live_vertices();
    ans.status = apsp_pkg::ST_OK;
    ans.distance = '0;
    ans.reach = 1'b0;
    case (kind)
      apsp_pkg::REQ_CLEAR: begin
        graph_edges = 0; tables_ok = 0; cycle_seen = 0;
      end
      apsp_pkg::REQ_ADD: begin
        if (int'(s) >= n || int'(d) >= n) ans.status = apsp_pkg::ST_RANGE;
        else if (graph_edges >= apsp_pkg::MAX_EDGES) ans.status = apsp_pkg::ST_FULL;
        else begin
          graph_src[graph_edges] = int'(s);
          graph_dst[graph_edges] = int'(d);
          graph_w[graph_edges] = longint'(w);
          graph_edges++;
          tables_ok = 0;
        end
      end
      apsp_pkg::REQ_COMPUTE: begin
        solves++;
        solve_graph();
      end
      default: begin
        if (int'(s) >= n || int'(d) >= n) ans.status = apsp_pkg::ST_RANGE;
        else if (!tables_ok) ans.status = apsp_pkg::ST_NO_RESULT;
        else if (reach_tab[s * apsp_pkg::MAX_VERTICES + d]) begin
          ans.reach = 1'b1;
          ans.distance = dist_tab[s * apsp_pkg::MAX_VERTICES + d];
        end
      end
    endcase
    ans.neg_cycle = cycle_seen;
    return ans;
  endfunction

  task automatic send_item(logic [1:0] kind, apsp_pkg::vert_t s, apsp_pkg::vert_t d,
                           apsp_pkg::weight_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.src_vertex <= s;
    req_ch.dst_vertex <= d;
    req_ch.edge_weight <= w;
    do @(posedge clk); while (!req_ch.ready);
    pending_answers.insert(pending_answers.size(), predict_answer(kind, s, d, w));
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [4:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.vertex_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    vert_cfg = value;
    tables_ok = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    path_answer_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d distance=%0d", $time, res_ch.status,
                 res_ch.distance);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (res_ch.status !== want.status || res_ch.distance !== want.distance ||
            res_ch.reachable !== want.reach || res_ch.negative_cycle !== want.neg_cycle) begin
          $display("%0t: mismatch expected st=%0d dist=%0d reach=%0d neg=%0d, %s",
                   $time, want.status, want.distance, want.reach, want.neg_cycle,
                   $sformatf("got st=%0d dist=%0d reach=%0d neg=%0d",
                             res_ch.status, res_ch.distance, res_ch.reachable,
                             res_ch.negative_cycle));
          errors++;
        end
      end
    end
  end

  task automatic test_small_graph();
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd0, '0);
    send_item(apsp_pkg::REQ_COMPUTE, '0, '0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd15, 4'd3, '0);
    write_vertex_count(5'd4);
    send_item(apsp_pkg::REQ_ADD, 4'd0, 4'd1, apsp_pkg::weight_t'(2047));
    send_item(apsp_pkg::REQ_ADD, 4'd1, 4'd2, apsp_pkg::weight_t'(-2048));
    send_item(apsp_pkg::REQ_ADD, 4'd2, 4'd3, apsp_pkg::weight_t'(5));
    send_item(apsp_pkg::REQ_ADD, 4'd5, 4'd0, apsp_pkg::weight_t'(1));
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd3, '0);
    send_item(apsp_pkg::REQ_COMPUTE, '0, '0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd3, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd3, 4'd0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd1, 4'd15, '0);
    // close a loop of total weight -1
    send_item(apsp_pkg::REQ_ADD, 4'd3, 4'd0, apsp_pkg::weight_t'(-5));
    send_item(apsp_pkg::REQ_COMPUTE, '0, '0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd1, '0);
    send_item(apsp_pkg::REQ_CLEAR, '0, '0, '0);
  endtask

  task automatic test_full_store();
    write_vertex_count(5'd31);
    send_item(apsp_pkg::REQ_CLEAR, '0, '0, '0);
    for (int i = 0; i < apsp_pkg::MAX_EDGES; i++)
      send_item(apsp_pkg::REQ_ADD, apsp_pkg::vert_t'(i % 16),
                apsp_pkg::vert_t'((i * 7 + 1) % 16),
                apsp_pkg::weight_t'($urandom_range(0, 2047)));
    send_item(apsp_pkg::REQ_ADD, 4'd0, 4'd1, apsp_pkg::weight_t'(1));
    send_item(apsp_pkg::REQ_COMPUTE, '0, '0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd15, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd9, 4'd2, '0);
    write_vertex_count(5'd2);
    // range check wins over full
    send_item(apsp_pkg::REQ_ADD, 4'd5, 4'd0, apsp_pkg::weight_t'(1));
    send_item(apsp_pkg::REQ_ADD, 4'd0, 4'd1, apsp_pkg::weight_t'(1));
    send_item(apsp_pkg::REQ_COMPUTE, '0, '0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd1, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd1, 4'd0, '0);
    write_vertex_count(5'd0);
    send_item(apsp_pkg::REQ_COMPUTE, '0, '0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd0, '0);
    send_item(apsp_pkg::REQ_QUERY, 4'd0, 4'd1, '0);
  endtask

  task automatic solve_random_graph(int n);
    int k;
    apsp_pkg::weight_t w;
    send_item(apsp_pkg::REQ_CLEAR, '0, '0, '0);
    k = $urandom_range(1, 2 * n);
    for (int i = 0; i < k; i++) begin
      w = ($urandom_range(99) < 80) ? apsp_pkg::weight_t'($urandom_range(0, 300))
                                    : apsp_pkg::weight_t'($urandom);
      if ($urandom_range(9) == 0)
        send_item(apsp_pkg::REQ_ADD, apsp_pkg::vert_t'($urandom), apsp_pkg::vert_t'($urandom),
                  w);
      else
        send_item(apsp_pkg::REQ_ADD, apsp_pkg::vert_t'($urandom_range(0, n - 1)),
                  apsp_pkg::vert_t'($urandom_range(0, n - 1)), w);
    end
    send_item(apsp_pkg::REQ_COMPUTE, '0, '0, '0);
    repeat ($urandom_range(3, 6)) begin
      if ($urandom_range(9) == 0)
        send_item(apsp_pkg::REQ_QUERY, apsp_pkg::vert_t'($urandom),
                  apsp_pkg::vert_t'($urandom), '0);
      else
        send_item(apsp_pkg::REQ_QUERY, apsp_pkg::vert_t'($urandom_range(0, n - 1)),
                  apsp_pkg::vert_t'($urandom_range(0, n - 1)), '0);
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int budget);
    int n;
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    n = $urandom_range(2, 6);
    write_vertex_count(5'(n));
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(4) == 0)
        send_item(2'($urandom), apsp_pkg::vert_t'($urandom), apsp_pkg::vert_t'($urandom),
                  apsp_pkg::weight_t'($urandom));
      else
        solve_random_graph(n);
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= apsp_pkg::REQ_CLEAR;
    req_ch.src_vertex <= '0;
    req_ch.dst_vertex <= '0;
    req_ch.edge_weight <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.vertex_count <= '0;
    graph_edges = 0;
    tables_ok = 0;
    cycle_seen = 0;
    vert_cfg = 5'd16;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_graph();
    test_full_store();
    test_random_phase(0, 0, 10);
    test_random_phase(63, 0, 10);
    test_random_phase(0, 63, 10);
    test_random_phase(12, 12, 10);
    write_vertex_count(5'd16);
    send_item(apsp_pkg::REQ_QUERY, 4'd15, 4'd15, '0);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d items, checked %0d results; %0d solves, %0d with a negative cycle.",
             items_sent, answers_seen, solves, cycles_hit);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
